// ===== rtl/packed_bitfield_array_top_defines.svh =====
// Assertion macros shared by the packed bitfield array checker.
`ifndef PACKED_BITFIELD_ARRAY_TOP_DEFINES_SVH
`define PACKED_BITFIELD_ARRAY_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pba_pkg.sv =====
// Types, constants and helper functions for the packed bitfield array.
package pba_pkg;

    localparam int DATA_W  = 64;
    localparam int IDX_W   = 12;
    localparam int FW_W    = 7;
    localparam int POS_W   = IDX_W + FW_W;
    localparam int SH_W    = 7;
    localparam int CFG_A_W = 1;

    localparam logic [CFG_A_W-1:0] CFG_FIELD_WIDTH = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_SIGNED_MODE = 1'b1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 7'd8;
    localparam logic [FW_W-1:0] FW_MAX   = 7'd64;

    typedef struct packed {
        logic [SH_W-1:0] sh;       // left shift from the LSB of the 128-bit pair
        logic [FW_W-1:0] width;    // effective field width, 1..64
        logic            hi_pass;  // working on the first (upper) word
    } pba_align_ctl_t;

    // Low n bits set, n in 1..64.
    function automatic logic [DATA_W-1:0] ones(input logic [FW_W-1:0] n);
        logic [DATA_W-1:0] r;
        if (n >= FW_MAX) r = '1;
        else r = (DATA_W'(1) << n) - DATA_W'(1);
        return r;
    endfunction

    // Clamp the programmed width to 1..64.
    function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] fw);
        logic [FW_W-1:0] r;
        if (fw == '0) r = FW_W'(1);
        else if (fw > FW_MAX) r = FW_MAX;
        else r = fw;
        return r;
    endfunction

endpackage

// ===== rtl/pba_align.sv =====
// Shared field alignment unit: merges a field into one word or extracts it.
module pba_align (
    input  pba_pkg::pba_align_ctl_t  ctl,
    input  logic [63:0]              mag,
    input  logic [63:0]              word_in,
    input  logic [63:0]              word_hi,
    output logic [63:0]              word_out,
    output logic [63:0]              field_out
);
    import pba_pkg::*;

    logic [2*DATA_W-1:0] mask_w;
    logic [2*DATA_W-1:0] data_w;
    logic [2*DATA_W-1:0] pair;
    logic [2*DATA_W-1:0] pair_sh;
    logic [DATA_W-1:0]   fmask;

    assign fmask  = ones(ctl.width);
    assign mask_w = {{DATA_W{1'b0}}, fmask} << ctl.sh;
    assign data_w = {{DATA_W{1'b0}}, mag} << ctl.sh;

    always_comb
    begin
        if (ctl.hi_pass)
        begin
            word_out = (word_in & ~mask_w[2*DATA_W-1:DATA_W]) | data_w[2*DATA_W-1:DATA_W];
            pair     = {word_in, {DATA_W{1'b0}}};
        end
        else
        begin
            word_out = (word_in & ~mask_w[DATA_W-1:0]) | data_w[DATA_W-1:0];
            pair     = {word_hi, word_in};
        end
    end

    assign pair_sh   = pair >> ctl.sh;
    assign field_out = pair_sh[DATA_W-1:0] & fmask;

endmodule

// ===== rtl/packed_bitfield_array_top.sv =====
// Top level of the packed bitfield array: sequencer, word store and sign store.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  command  | start / busy       | mode, index, value
//  result   | done (1-cycle)     | read_value
//  config   | cfg_wr             | cfg_addr, cfg_data
//
// A command is taken when start is high and busy is low; busy stays high
// until the item is finished. An entry in one word passes RD0 and MOD0, and a
// read then OUT, after which done is raised; an entry that straddles two words
// adds RD1 and MOD1, since the single port of the word store takes one
// read-modify-write pass per word through the shared alignment unit. A write
// to an index out of range is dropped; such a read goes to OUT and returns zero.
// Reset clears control state and configuration; the stores start undefined.
// The receiver cannot stall: each done pulse carries one word and goes away.
module packed_bitfield_array_top #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [pba_pkg::IDX_W-1:0]     index,
    input  logic signed [63:0]            value,
    output logic                          done,
    output logic signed [63:0]            read_value,
    input  logic                          cfg_wr,
    input  logic [pba_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [pba_pkg::FW_W-1:0]      cfg_data
);
    import pba_pkg::*;

    localparam int WORD_DEPTH = MAX_ENTRIES + 1;
    localparam int WADDR_W    = $clog2(WORD_DEPTH);
    localparam int SIGN_DEPTH = (MAX_ENTRIES + 63) / 64;
    localparam int SADDR_W    = (SIGN_DEPTH > 1) ? $clog2(SIGN_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD0  = 3'd1;
    localparam logic [2:0] ST_MOD0 = 3'd2;
    localparam logic [2:0] ST_RD1  = 3'd3;
    localparam logic [2:0] ST_MOD1 = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // Configuration registers
    logic [FW_W-1:0]   fw_reg;
    logic              sm_reg;

    // Sequencer and per-item context
    logic [2:0]        state_reg,    state_next;
    logic              done_reg,     done_next;
    logic              mode_reg,     mode_next;
    logic              zero_reg,     zero_next;
    logic [IDX_W-1:0]  idx_reg,      idx_next;
    logic [FW_W-1:0]   width_reg,    width_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [SH_W-1:0]   sh_reg,       sh_next;
    logic              straddle_reg, straddle_next;
    logic              neg_reg,      neg_next;
    logic [63:0]       mag_reg,      mag_next;
    logic [63:0]       word_hi_reg,  word_hi_next;
    logic [63:0]       rv_reg,       rv_next;

    // Stores
    logic [63:0]       word_mem [WORD_DEPTH];
    logic [63:0]       sign_mem [SIGN_DEPTH];
    logic [63:0]       word_rdata_reg;
    logic [63:0]       sign_rdata_reg;

    logic              accept;
    logic              out_of_range;
    logic [63:0]       value_u;
    logic [63:0]       value_abs;
    logic [7:0]        end_bit;
    logic [WADDR_W-1:0] wi;
    logic [WADDR_W-1:0] word_addr;
    logic              word_we;
    logic [SADDR_W-1:0] sign_addr;
    logic              sign_we;
    logic [63:0]       sign_wdata;
    logic              sign_bit;
    logic [5:0]        sign_pos;

    pba_align_ctl_t    align_ctl;
    logic [63:0]       align_word;
    logic [63:0]       align_field;

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign accept     = start && !busy;

    assign out_of_range = (32'(index) >= MAX_ENTRIES);
    assign value_u      = $unsigned(value);
    assign value_abs    = (sm_reg && value_u[63]) ? (64'd0 - value_u) : value_u;

    // Field end, counted from the MSB of the first word; past 64 it straddles.
    assign end_bit = {2'b00, pos_reg[5:0]} + {1'b0, width_reg};

    assign wi        = WADDR_W'(pos_reg[POS_W-1:6]);
    assign word_addr = (state_reg == ST_RD1 || state_reg == ST_MOD1) ? wi + WADDR_W'(1) : wi;
    assign word_we   = (mode_reg == MODE_WRITE) &&
                       (state_reg == ST_MOD0 || state_reg == ST_MOD1);

    // Sign bits go MSB-first within a sign word.
    assign sign_addr  = SADDR_W'(idx_reg[IDX_W-1:6]);
    assign sign_pos   = ~idx_reg[5:0];
    assign sign_bit   = sign_rdata_reg[sign_pos];
    assign sign_we    = (mode_reg == MODE_WRITE) && sm_reg && (state_reg == ST_MOD0);

    always_comb
    begin
        sign_wdata           = sign_rdata_reg;
        sign_wdata[sign_pos] = neg_reg;
    end

    assign align_ctl.sh      = sh_reg;
    assign align_ctl.width   = width_reg;
    assign align_ctl.hi_pass = (state_reg == ST_MOD0);

    pba_align u_align (
        .ctl       (align_ctl),
        .mag       (mag_reg),
        .word_in   (word_rdata_reg),
        .word_hi   (word_hi_reg),
        .word_out  (align_word),
        .field_out (align_field)
    );

    // Word store: one port, read data registered.
    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_addr] <= align_word;
        end
        word_rdata_reg <= word_mem[word_addr];
    end

    // Sign store: one port, read data registered.
    always_ff @(posedge clk)
    begin
        if (sign_we)
        begin
            sign_mem[sign_addr] <= sign_wdata;
        end
        sign_rdata_reg <= sign_mem[sign_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        mode_next     = mode_reg;
        zero_next     = zero_reg;
        idx_next      = idx_reg;
        width_next    = width_reg;
        pos_next      = pos_reg;
        sh_next       = sh_reg;
        straddle_next = straddle_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        word_hi_next  = word_hi_reg;
        rv_next       = rv_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Latch the command and place the entry in the bit stream.
                    mode_next  = mode;
                    idx_next   = index;
                    width_next = eff_width(fw_reg);
                    pos_next   = POS_W'(width_next) * POS_W'(index);
                    neg_next   = sm_reg && value_u[63];
                    mag_next   = value_abs & ones(width_next);
                    zero_next  = out_of_range;
                    if (!out_of_range)
                    begin
                        state_next = ST_RD0;
                    end
                    else if (mode == MODE_READ)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RD0:
            begin
                // Store reads are under way; size up the field.
                straddle_next = (end_bit > 8'd64);
                sh_next       = SH_W'(8'd128 - end_bit);
                state_next    = ST_MOD0;
            end
            ST_MOD0:
            begin
                if (mode_reg == MODE_READ)
                begin
                    neg_next     = sm_reg && sign_bit;
                    word_hi_next = word_rdata_reg;
                    mag_next     = align_field;
                end
                if (straddle_reg)
                begin
                    state_next = ST_RD1;
                end
                else if (mode_reg == MODE_READ)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD1:
            begin
                state_next = ST_MOD1;
            end
            ST_MOD1:
            begin
                if (mode_reg == MODE_READ)
                begin
                    mag_next   = align_field;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                // Apply the sign (or zero for an index out of range), register the result word and raise done.
                if (zero_reg) rv_next = 64'd0;
                else if (neg_reg) rv_next = 64'd0 - mag_reg;
                else rv_next = mag_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            fw_reg    <= FW_RESET;
            sm_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_wr)
            begin
                unique case (cfg_addr)
                    CFG_FIELD_WIDTH: fw_reg <= cfg_data;
                    CFG_SIGNED_MODE: sm_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        zero_reg     <= zero_next;
        idx_reg      <= idx_next;
        width_reg    <= width_next;
        pos_reg      <= pos_next;
        sh_reg       <= sh_next;
        straddle_reg <= straddle_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        word_hi_reg  <= word_hi_next;
        rv_reg       <= rv_next;
    end

endmodule

// ===== rtl/pba_checker.sv =====
// Port-level checker for the packed bitfield array, bound to the top level.
`include "packed_bitfield_array_top_defines.svh"

module pba_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic mode,
    input logic done
);
    import pba_pkg::*;

    logic rd_accept;
    logic wr_accept;

    assign rd_accept = start && !busy && (mode == MODE_READ);
    assign wr_accept = start && !busy && (mode == MODE_WRITE);

    // A read always leaves the block busy in the cycle after it is taken.
    `PBA_ASSERT_NEXT(a_read_busy, clk, rst_n, rd_accept, busy, "read accepted but not busy")

    // A write never produces a result right after it is taken.
    `PBA_ASSERT_NEXT(a_write_quiet, clk, rst_n, wr_accept, !done, "result after a write")

    // A result comes out as the block goes idle.
    `PBA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result while busy")

    // A result lasts a single cycle.
    `PBA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result held over two cycles")

endmodule

bind packed_bitfield_array_top pba_checker u_pba_checker (.*);
